// ===== hw/rtl/tws_pkg.sv =====
package tws_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TRADE = 2'd0;
  localparam logic [1:0] OP_QUOTE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Field widths.
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int TIME_W   = 48;
  localparam int SPREAD_W = 33;
  localparam int VOL_W    = 38;
  localparam int VOLAT_W  = 40;
  localparam int CNT_W    = 7;

  // Reset value of the volume window and saturation limits.
  localparam logic [TIME_W-1:0]  WIN_RESET = 48'd1000000;
  localparam logic [63:0]        VOL_MAX   = 64'h3F_FFFF_FFFF;
  localparam logic [63:0]        VOLAT_MAX = 64'hFF_FFFF_FFFF;
  localparam logic [15:0]        CNT_MAX   = 16'd127;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic trade_wr;
    logic quote_wr;
    logic acc_clr;
    logic rd_issue;
    logic mul_load_a;
    logic mul_load_b;
    logic mul_step;
    logic div_load_v;
    logic div_load_y;
    logic div_step;
    logic vwap_cap;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } tws_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } tws_sts_t;

endpackage

// ===== hw/rtl/tws_ram.sv =====
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tws_ctrl.sv =====
module tws_ctrl import tws_pkg::*; #(
  parameter int WINDOW_TRADES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic [1:0]                           in_op,
  output logic                                 in_stall,
  input  logic [$clog2(WINDOW_TRADES+1)-1:0]   n_count,
  input  tws_sts_t                             sts,
  output tws_cmd_t                             cmd,
  output logic [(WINDOW_TRADES > 1 ? $clog2(WINDOW_TRADES) : 1)-1:0] rd_addr
);

  localparam int AW  = (WINDOW_TRADES > 1) ? $clog2(WINDOW_TRADES) : 1;
  localparam int CW  = $clog2(WINDOW_TRADES + 1);
  localparam int SQW = 32 + CW;
  localparam int NW  = 64 + 2 * CW;
  localparam int YW  = NW + 16;
  localparam int SW2 = YW + (YW % 2);
  localparam int RW  = SW2 / 2;
  localparam int TW  = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_DRAIN, S_MLA, S_MRA, S_MLB, S_MRB,
    S_DVL, S_DVR, S_VWC, S_DYR, S_SQL, S_SQR, S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [TW-1:0] cnt_r, cnt_nxt;
  logic          in_fire;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign rd_addr  = cnt_r[AW-1:0];

  // Commands decoded from the current state and from the accepted input item.
  always_comb begin
    cmd            = '0;
    cmd.trade_wr   = in_fire && (in_op == OP_TRADE);
    cmd.quote_wr   = in_fire && (in_op == OP_QUOTE);
    cmd.acc_clr    = in_fire && (in_op == OP_QUERY);
    cmd.rd_issue   = (state_r == S_WALK) && (cnt_r < TW'(n_count));
    cmd.mul_load_a = (state_r == S_MLA);
    cmd.mul_load_b = (state_r == S_MLB);
    cmd.mul_step   = (state_r == S_MRA) || (state_r == S_MRB);
    cmd.div_load_v = (state_r == S_DVL);
    cmd.div_load_y = (state_r == S_VWC);
    cmd.vwap_cap   = (state_r == S_VWC);
    cmd.div_step   = (state_r == S_DVR) || (state_r == S_DYR);
    cmd.sqrt_load  = (state_r == S_SQL);
    cmd.sqrt_step  = (state_r == S_SQR);
    cmd.out_load   = (state_r == S_OUT) && !sts.out_busy;
  end

  // Sequencing of the query phases.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + TW'(1);
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (cmd.acc_clr) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (cnt_r >= TW'(n_count)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end
      end
      S_DRAIN: begin
        if (cnt_r == TW'(3)) begin
          state_nxt = S_MLA;
        end
      end
      S_MLA: begin
        state_nxt = S_MRA;
        cnt_nxt   = '0;
      end
      S_MRA: begin
        if (cnt_r == TW'(SQW - 1)) begin
          state_nxt = S_MLB;
        end
      end
      S_MLB: begin
        state_nxt = S_MRB;
        cnt_nxt   = '0;
      end
      S_MRB: begin
        if (cnt_r == TW'(SQW - 1)) begin
          state_nxt = S_DVL;
        end
      end
      S_DVL: begin
        state_nxt = S_DVR;
        cnt_nxt   = '0;
      end
      S_DVR: begin
        if (cnt_r == TW'(YW - 1)) begin
          state_nxt = S_VWC;
        end
      end
      S_VWC: begin
        state_nxt = S_DYR;
        cnt_nxt   = '0;
      end
      S_DYR: begin
        if (cnt_r == TW'(YW - 1)) begin
          state_nxt = S_SQL;
        end
      end
      S_SQL: begin
        state_nxt = S_SQR;
        cnt_nxt   = '0;
      end
      S_SQR: begin
        if (cnt_r == TW'(RW - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/tws_dp.sv =====
module tws_dp import tws_pkg::*; #(
  parameter int WINDOW_TRADES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tws_cmd_t                             cmd,
  output tws_sts_t                             sts,
  input  logic [(WINDOW_TRADES > 1 ? $clog2(WINDOW_TRADES) : 1)-1:0] rd_addr,
  output logic [$clog2(WINDOW_TRADES+1)-1:0]   n_count,
  input  logic [PRICE_W-1:0]                   in_trade_price,
  input  logic [QTY_W-1:0]                     in_trade_quantity,
  input  logic [PRICE_W-1:0]                   in_bid_price,
  input  logic [PRICE_W-1:0]                   in_ask_price,
  input  logic [TIME_W-1:0]                    in_timestamp,
  input  logic                                 cfg_we,
  input  logic [TIME_W-1:0]                    cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          out_vwap,
  output logic signed [SPREAD_W-1:0]           out_spread,
  output logic [VOL_W-1:0]                     out_window_volume,
  output logic [VOLAT_W-1:0]                   out_volatility,
  output logic [CNT_W-1:0]                     out_trade_count
);

  localparam int AW  = (WINDOW_TRADES > 1) ? $clog2(WINDOW_TRADES) : 1;
  localparam int CW  = $clog2(WINDOW_TRADES + 1);
  localparam int SQW = 32 + CW;
  localparam int SPW = 64 + CW;
  localparam int NW  = 64 + 2 * CW;
  localparam int YW  = NW + 16;
  localparam int SW2 = YW + (YW % 2);
  localparam int RW  = SW2 / 2;
  localparam int EW  = TIME_W + QTY_W + PRICE_W;

  // Ring state and registers.
  logic [AW-1:0]      wp_r;
  logic               full_r;
  logic [PRICE_W-1:0] bid_r, ask_r;
  logic [TIME_W-1:0]  win_r, now_r;
  logic [EW-1:0]      rdata;

  tws_ram #(.WIDTH(EW), .DEPTH(WINDOW_TRADES)) u_ring (
    .clk     (clk),
    .we      (cmd.trade_wr),
    .waddr   (wp_r),
    .wdata   ({in_timestamp, in_trade_quantity, in_trade_price}),
    .raddr   (rd_addr),
    .rdata_r (rdata)
  );

  assign n_count = full_r ? CW'(WINDOW_TRADES) : CW'(wp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
      bid_r  <= '0;
      ask_r  <= '0;
      win_r  <= WIN_RESET;
    end else begin
      if (cmd.trade_wr) begin
        if (wp_r == AW'(WINDOW_TRADES - 1)) begin
          wp_r   <= '0;
          full_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end
      if (cmd.quote_wr) begin
        bid_r <= in_bid_price;
        ask_r <= in_ask_price;
      end
      if (cfg_we) begin
        win_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      now_r <= in_timestamp;
    end
  end

  // Walk pipeline: read, multiply, accumulate.
  logic               rdv_r, mv_r;
  logic [PRICE_W-1:0] p_rd, p2_r;
  logic [QTY_W-1:0]   q_rd, q2_r;
  logic [TIME_W-1:0]  t_rd;
  logic               in_win, win2_r;
  logic [63:0]        pq_r, pp_r;
  logic [SPW-1:0]     spq_r, s2_r;
  logic [SQW-1:0]     sq_r, s1_r, vol_r;

  assign p_rd   = rdata[PRICE_W-1:0];
  assign q_rd   = rdata[PRICE_W+QTY_W-1:PRICE_W];
  assign t_rd   = rdata[EW-1:PRICE_W+QTY_W];
  assign in_win = (t_rd > now_r) || ((now_r - t_rd) < win_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
      mv_r  <= 1'b0;
    end else begin
      rdv_r <= cmd.rd_issue;
      mv_r  <= rdv_r;
    end
  end

  always_ff @(posedge clk) begin
    pq_r   <= 64'(p_rd) * 64'(q_rd);
    pp_r   <= 64'(p_rd) * 64'(p_rd);
    p2_r   <= p_rd;
    q2_r   <= q_rd;
    win2_r <= in_win;
    if (cmd.acc_clr) begin
      spq_r <= '0;
      s2_r  <= '0;
      sq_r  <= '0;
      s1_r  <= '0;
      vol_r <= '0;
    end else if (mv_r) begin
      spq_r <= spq_r + SPW'(pq_r);
      s2_r  <= s2_r + SPW'(pp_r);
      sq_r  <= sq_r + SQW'(q2_r);
      s1_r  <= s1_r + SQW'(p2_r);
      if (win2_r) begin
        vol_r <= vol_r + SQW'(q2_r);
      end
    end
  end

  // Shift-add multiplier for n*s2 and s1*s1.
  logic [NW-1:0]  mcand_r, macc_r, prod1_r;
  logic [SQW-1:0] mplier_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_load_a) begin
      mcand_r  <= NW'(s2_r);
      mplier_r <= SQW'(n_count);
      macc_r   <= '0;
    end else if (cmd.mul_load_b) begin
      prod1_r  <= macc_r;
      mcand_r  <= NW'(s1_r);
      mplier_r <= s1_r;
      macc_r   <= '0;
    end else if (cmd.mul_step) begin
      if (mplier_r[0]) begin
        macc_r <= macc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[NW-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[SQW-1:1]};
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [YW-1:0]    dq_r;
  logic [SQW-1:0]   rem_r, dv_r;
  logic [SQW:0]     dtrial, ddiff;
  logic             dge;
  logic [NW-1:0]    num;
  logic [2*CW-1:0]  nn1;
  logic [31:0]      vwap_r;
  logic             volat_en_r;

  assign dtrial = {rem_r, dq_r[YW-1]};
  assign dge    = dtrial >= {1'b0, dv_r};
  assign ddiff  = dtrial - {1'b0, dv_r};
  assign num    = prod1_r - macc_r;
  assign nn1    = (2*CW)'(n_count) * (2*CW)'(n_count - CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.vwap_cap) begin
      vwap_r <= dq_r[31:0];
    end
    if (cmd.div_load_v) begin
      dq_r  <= YW'(spq_r);
      dv_r  <= sq_r;
      rem_r <= '0;
    end else if (cmd.div_load_y) begin
      dq_r       <= {num, 16'b0};
      dv_r       <= SQW'(nn1);
      rem_r      <= '0;
      volat_en_r <= (num != '0) && (n_count >= CW'(2));
    end else if (cmd.div_step) begin
      rem_r <= dge ? ddiff[SQW-1:0] : dtrial[SQW-1:0];
      dq_r  <= {dq_r[YW-2:0], dge};
    end
  end

  // Digit-by-digit square root, one root bit per cycle.
  logic [SW2-1:0] sx_r;
  logic [RW-1:0]  root_r;
  logic [RW+1:0]  srem_r, scur, strial;
  logic           sge;

  assign scur   = {srem_r[RW-1:0], sx_r[SW2-1:SW2-2]};
  assign strial = {root_r, 2'b01};
  assign sge    = scur >= strial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sx_r   <= SW2'(dq_r);
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      sx_r   <= {sx_r[SW2-3:0], 2'b00};
      srem_r <= sge ? (scur - strial) : scur;
      root_r <= {root_r[RW-2:0], sge};
    end
  end

  // Result register.
  logic [63:0] vol64, root64;
  logic [15:0] cnt16;

  assign vol64  = 64'(vol_r);
  assign root64 = 64'(root_r);
  assign cnt16  = 16'(n_count);
  assign sts.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_vwap <= (sq_r != '0) ? vwap_r : 32'd0;
      if ((bid_r != '0) && (ask_r != '0)) begin
        out_spread <= SPREAD_W'(ask_r) - SPREAD_W'(bid_r);
      end else begin
        out_spread <= '0;
      end
      out_window_volume <= (vol64 > VOL_MAX) ? VOL_MAX[VOL_W-1:0] : vol64[VOL_W-1:0];
      if (!volat_en_r) begin
        out_volatility <= '0;
      end else if (root64 > VOLAT_MAX) begin
        out_volatility <= VOLAT_MAX[VOLAT_W-1:0];
      end else begin
        out_volatility <= root64[VOLAT_W-1:0];
      end
      out_trade_count <= (cnt16 > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : cnt16[CNT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/trade_window_stats.sv =====
// Trade and quote items are accepted back to back while no query is in progress.
// A query runs from its accept to its result through the ring walk, a shift-add
// multiplier, a bit-serial divider and a bit-serial square root, and its result
// can further be held by a result stall; no item is accepted meanwhile.
// Synchronous active-low reset empties the ring, clears bid and ask and loads the
// volume window with 1000000 ticks; the ring memory itself is not cleared.
module trade_window_stats import tws_pkg::*; #(
  parameter int WINDOW_TRADES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [PRICE_W-1:0]         in_trade_price,
  input  logic [QTY_W-1:0]           in_trade_quantity,
  input  logic [PRICE_W-1:0]         in_bid_price,
  input  logic [PRICE_W-1:0]         in_ask_price,
  input  logic [TIME_W-1:0]          in_timestamp,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_vwap,
  output logic signed [SPREAD_W-1:0] out_spread,
  output logic [VOL_W-1:0]           out_window_volume,
  output logic [VOLAT_W-1:0]         out_volatility,
  output logic [CNT_W-1:0]           out_trade_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [TIME_W-1:0]          cfg_volume_window_ticks
);

  localparam int AW = (WINDOW_TRADES > 1) ? $clog2(WINDOW_TRADES) : 1;
  localparam int CW = $clog2(WINDOW_TRADES + 1);

  tws_cmd_t      cmd;
  tws_sts_t      sts;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] n_count;

  // The register is always writable.
  assign cfg_ready = 1'b1;

  tws_ctrl #(.WINDOW_TRADES(WINDOW_TRADES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .n_count  (n_count),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  tws_dp #(.WINDOW_TRADES(WINDOW_TRADES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .rd_addr           (rd_addr),
    .n_count           (n_count),
    .in_trade_price    (in_trade_price),
    .in_trade_quantity (in_trade_quantity),
    .in_bid_price      (in_bid_price),
    .in_ask_price      (in_ask_price),
    .in_timestamp      (in_timestamp),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_volume_window_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_vwap          (out_vwap),
    .out_spread        (out_spread),
    .out_window_volume (out_window_volume),
    .out_volatility    (out_volatility),
    .out_trade_count   (out_trade_count)
  );

endmodule
